@@ rtl/core/pip_pkg.sv @@
// Shared types and constants for the point-in-polygon crossing test.
`default_nettype none

package pip_pkg;

  // Configuration port: two registers, one word apart.
  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 32;

  // Register index, taken from bit 2 of the byte address.
  localparam logic RegPointX = 1'b0;
  localparam logic RegPointY = 1'b1;

  // Control that travels alongside each vertex through the pipeline.
  typedef struct packed {
    logic prev_edge_en;  // the edge from the previous vertex is real
    logic last;          // this vertex closes the polygon
    logic enough;        // the polygon has at least three vertices
  } pip_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/point_in_polygon_test.sv @@
// Top level of the crossing-number point-in-polygon test.
//
//   Channel   Direction  Handshake                      Beat contents
//   vertex    in         vertex_valid_i/vertex_ready_o  vertex_x_i, vertex_y_i, last_vertex_i
//   result    out        result_valid_o/result_ready_i  inside_res_o, too_few_vertices_o
//   config    in         APB (psel/penable/pwrite)      point_x at 0x0, point_y at 0x4
//
// One vertex beat is taken every cycle unless the pipe has stalled. A vertex
// passes three registers: the entry register (edge endpoints captured), the
// product register (the two cross-product terms of each edge, one multiplier
// each) and the result register. The multipliers in the product stage set
// the cycle time.
// Reset clears the vertex tally, the crossing parity, the query point and
// every valid flag. A stalled result holds only the final stage: vertices that
// close no polygon keep flowing, and the pipe stops only behind a second
// closing vertex that has nowhere to go.
`default_nettype none

module point_in_polygon_test import pip_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Vertex channel
  input  wire logic                           vertex_valid_i,
  output logic                                vertex_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0]  vertex_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]  vertex_y_i,
  input  wire logic                           last_vertex_i,
  // Result channel
  output logic                                result_valid_o,
  input  wire logic                           result_ready_i,
  output logic                                inside_res_o,
  output logic                                too_few_vertices_o,
  // Configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [CfgAddrWidth-1:0]        paddr,
  input  wire logic [CfgDataWidth-1:0]        pwdata,
  output logic [CfgDataWidth-1:0]             prdata,
  output logic                                pready
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned PW = 2 * CW + 2;

  // ---------------------------------------------------------------------
  // Configuration registers: the query point.
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] point_x_q, point_y_q;
  logic                 cfg_write;
  logic                 cfg_sel;

  assign pready    = 1'b1;
  assign cfg_sel   = paddr[2];
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_x_q <= '0;
      point_y_q <= '0;
    end else if (cfg_write) begin
      if (cfg_sel == RegPointX) begin
        point_x_q <= pwdata[CW-1:0];
      end
      if (cfg_sel == RegPointY) begin
        point_y_q <= pwdata[CW-1:0];
      end
    end
  end

  // Reads return the stored point, sign-extended to the bus width.
  always_comb begin
    if (cfg_sel == RegPointY) begin
      prdata = {{(CfgDataWidth-CW){point_y_q[CW-1]}}, point_y_q};
    end else begin
      prdata = {{(CfgDataWidth-CW){point_x_q[CW-1]}}, point_x_q};
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control. Only a closing vertex needs the result register.
  // ---------------------------------------------------------------------
  logic      a_valid_q, b_valid_q;
  pip_ctrl_t a_ctrl_q, b_ctrl_q, a_ctrl_d;
  logic      out_free, b_retire, b_free, a_move, a_free, accept;

  assign out_free       = ~result_valid_o | result_ready_i;
  assign b_retire       = b_valid_q & (~b_ctrl_q.last | out_free);
  assign b_free         = ~b_valid_q | b_retire;
  assign a_move         = a_valid_q & b_free;
  assign a_free         = ~a_valid_q | a_move;
  assign vertex_ready_o = a_free;
  assign accept         = vertex_valid_i & a_free;

  // ---------------------------------------------------------------------
  // Polygon tracking at entry: first vertex, previous vertex and tally.
  // The tally saturates at three and restarts after a closing vertex.
  // ---------------------------------------------------------------------
  logic [1:0]           tally_q, tally_d;
  logic signed [CW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [CW-1:0] close_bx, close_by;

  always_comb begin
    a_ctrl_d.prev_edge_en = tally_q != 2'd0;
    a_ctrl_d.last         = last_vertex_i;
    a_ctrl_d.enough       = tally_q >= 2'd2;
    // The closing edge runs back to the first vertex, which is this one
    // when the polygon has a single vertex.
    close_bx = (tally_q == 2'd0) ? vertex_x_i : first_x_q;
    close_by = (tally_q == 2'd0) ? vertex_y_i : first_y_q;
    if (last_vertex_i) begin
      tally_d = 2'd0;
    end else if (tally_q == 2'd3) begin
      tally_d = tally_q;
    end else begin
      tally_d = tally_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q   <= 2'd0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        tally_q <= tally_d;
      end
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (a_move) begin
        a_valid_q <= 1'b0;
      end
      if (a_move) begin
        b_valid_q <= 1'b1;
      end else if (b_retire) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  // Entry register: endpoints of both edges and the point they are tested against.
  logic signed [CW-1:0] e0_ax_q, e0_ay_q, e1_bx_q, e1_by_q;
  logic signed [CW-1:0] v_x_q, v_y_q, pt_x_q, pt_y_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (tally_q == 2'd0) begin
        first_x_q <= vertex_x_i;
        first_y_q <= vertex_y_i;
      end
      prev_x_q <= vertex_x_i;
      prev_y_q <= vertex_y_i;
      a_ctrl_q <= a_ctrl_d;
      e0_ax_q  <= prev_x_q;
      e0_ay_q  <= prev_y_q;
      v_x_q    <= vertex_x_i;
      v_y_q    <= vertex_y_i;
      e1_bx_q  <= close_bx;
      e1_by_q  <= close_by;
      pt_x_q   <= point_x_q;
      pt_y_q   <= point_y_q;
    end
    if (a_move) begin
      b_ctrl_q <= a_ctrl_q;
    end
  end

  // ---------------------------------------------------------------------
  // Product stage: one unit for the edge from the previous vertex and one
  // for the closing edge.
  // ---------------------------------------------------------------------
  logic signed [PW-1:0] prev_pa, prev_pb, close_pa, close_pb;
  logic                 prev_span, prev_eyn, close_span, close_eyn;

  pip_edge_prod #(
    .COORD_WIDTH(CW)
  ) u_prev_edge (
    .clk_i    (clk_i),
    .en_i     (a_move),
    .a_x_i    (e0_ax_q),
    .a_y_i    (e0_ay_q),
    .b_x_i    (v_x_q),
    .b_y_i    (v_y_q),
    .pt_x_i   (pt_x_q),
    .pt_y_i   (pt_y_q),
    .prod_a_o (prev_pa),
    .prod_b_o (prev_pb),
    .span_o   (prev_span),
    .ey_neg_o (prev_eyn)
  );

  pip_edge_prod #(
    .COORD_WIDTH(CW)
  ) u_close_edge (
    .clk_i    (clk_i),
    .en_i     (a_move),
    .a_x_i    (v_x_q),
    .a_y_i    (v_y_q),
    .b_x_i    (e1_bx_q),
    .b_y_i    (e1_by_q),
    .pt_x_i   (pt_x_q),
    .pt_y_i   (pt_y_q),
    .prod_a_o (close_pa),
    .prod_b_o (close_pb),
    .span_o   (close_span),
    .ey_neg_o (close_eyn)
  );

  // ---------------------------------------------------------------------
  // Crossing decision, parity and the result register.
  // ---------------------------------------------------------------------
  pip_parity #(
    .COORD_WIDTH(CW)
  ) u_parity (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .retire_i       (b_retire),
    .ctrl_i         (b_ctrl_q),
    .prev_prod_a_i  (prev_pa),
    .prev_prod_b_i  (prev_pb),
    .prev_span_i    (prev_span),
    .prev_ey_neg_i  (prev_eyn),
    .close_prod_a_i (close_pa),
    .close_prod_b_i (close_pb),
    .close_span_i   (close_span),
    .close_ey_neg_i (close_eyn),
    .out_ready_i    (result_ready_i),
    .out_valid_o    (result_valid_o),
    .inside_o       (inside_res_o),
    .too_few_o      (too_few_vertices_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/pip_edge_prod.sv @@
// Product stage for one edge: span test and the two cross-product terms, registered.
`default_nettype none

module pip_edge_prod import pip_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic signed [COORD_WIDTH-1:0]     a_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]     a_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]     b_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]     b_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]     pt_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]     pt_y_i,
  output logic signed [2*COORD_WIDTH+1:0]        prod_a_o,
  output logic signed [2*COORD_WIDTH+1:0]        prod_b_o,
  output logic                                   span_o,
  output logic                                   ey_neg_o
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;

  logic signed [DW-1:0] ey, ex, dx, dy;
  logic                 a_above, b_above;
  logic signed [PW-1:0] prod_a_d, prod_b_d;
  logic signed [PW-1:0] prod_a_q, prod_b_q;
  logic                 span_q, ey_neg_q;

  always_comb begin
    ey       = DW'(b_y_i) - DW'(a_y_i);
    ex       = DW'(b_x_i) - DW'(a_x_i);
    dx       = DW'(pt_x_i) - DW'(a_x_i);
    dy       = DW'(pt_y_i) - DW'(a_y_i);
    a_above  = a_y_i > pt_y_i;
    b_above  = b_y_i > pt_y_i;
    prod_a_d = PW'(ey) * PW'(dx);
    prod_b_d = PW'(ex) * PW'(dy);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_a_q <= prod_a_d;
      prod_b_q <= prod_b_d;
      span_q   <= a_above ^ b_above;
      // Inside the span the edge runs downwards exactly when its start is above.
      ey_neg_q <= a_above;
    end
  end

  assign prod_a_o = prod_a_q;
  assign prod_b_o = prod_b_q;
  assign span_o   = span_q;
  assign ey_neg_o = ey_neg_q;

endmodule

`default_nettype wire

@@ rtl/core/pip_parity.sv @@
// Crossing decision, running parity and the result register.
`default_nettype none

module pip_parity import pip_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              retire_i,
  input  wire pip_ctrl_t                         ctrl_i,
  input  wire logic signed [2*COORD_WIDTH+1:0]   prev_prod_a_i,
  input  wire logic signed [2*COORD_WIDTH+1:0]   prev_prod_b_i,
  input  wire logic                              prev_span_i,
  input  wire logic                              prev_ey_neg_i,
  input  wire logic signed [2*COORD_WIDTH+1:0]   close_prod_a_i,
  input  wire logic signed [2*COORD_WIDTH+1:0]   close_prod_b_i,
  input  wire logic                              close_span_i,
  input  wire logic                              close_ey_neg_i,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic                                   inside_o,
  output logic                                   too_few_o
);

  localparam int unsigned CPW = 2 * COORD_WIDTH + 3;

  logic signed [CPW-1:0] prev_c, close_c;
  logic                  prev_cross, close_cross, parity_next;
  logic                  parity_q, out_valid_q, inside_q, too_few_q;

  always_comb begin
    prev_c      = CPW'(prev_prod_a_i) - CPW'(prev_prod_b_i);
    close_c     = CPW'(close_prod_a_i) - CPW'(close_prod_b_i);
    // A point on the edge counts; otherwise the cross product must oppose the y extent.
    prev_cross  = prev_span_i &
                  ((prev_c == '0) | (prev_c[CPW-1] != prev_ey_neg_i));
    close_cross = close_span_i &
                  ((close_c == '0) | (close_c[CPW-1] != close_ey_neg_i));
    parity_next = parity_q ^ (ctrl_i.prev_edge_en & prev_cross)
                           ^ (ctrl_i.last & close_cross);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (retire_i) begin
        parity_q <= ctrl_i.last ? 1'b0 : parity_next;
      end
      if (retire_i && ctrl_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (retire_i && ctrl_i.last) begin
      inside_q  <= ctrl_i.enough & parity_next;
      too_few_q <= ~ctrl_i.enough;
    end
  end

  assign out_valid_o = out_valid_q;
  assign inside_o    = inside_q;
  assign too_few_o   = too_few_q;

endmodule

`default_nettype wire
